// ----- rtl/lcfs_pkg.sv -----
package lcfs_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned WORD_W = 32;

  // fade step is the difference divided by 16, plus one
  localparam int unsigned STEP_DIV_LOG2 = 4;
  localparam logic [WORD_W-1:0] STEP_ROUND_BIAS = WORD_W'((1 << STEP_DIV_LOG2) - 1);
  localparam int unsigned SIGN_BIT = WORD_W - 1;

  localparam int unsigned LED_RESET_POS = 25;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // fade registers as seen by the tick datapath
  typedef struct packed {
    logic [WORD_W-1:0]        goal;
    logic [WORD_W-1:0]        pend;
    logic signed [WORD_W-1:0] step;
  } fade_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              done;
    fade_state_t       state;
  } tick_res_t;

endpackage

// ----- rtl/lcfs_if.sv -----
interface lcfs_in_if;
  import lcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   led_index;
  logic [WORD_W-1:0]  colour_word;

  modport source (output valid, operation, led_index, colour_word, input ready);
  modport sink (input valid, operation, led_index, colour_word, output ready);
endinterface

interface lcfs_out_if;
  import lcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   affected_index;
  logic [WORD_W-1:0]  result_word;
  logic               fade_done;

  modport source (output valid, affected_index, result_word, fade_done, input ready);
  modport sink (input valid, affected_index, result_word, fade_done, output ready);
endinterface

// ----- rtl/led_chase_fade_stepper_unit.sv -----
// pipeline: stage one, then the output register; stage one holds on a stall
// throughput: one word per cycle unless stalled, one frame read-modify-write
//   per word with the previous word's write forwarded into the next read
// reset: control and fade registers clear at once, then a sweep zeroes the
//   frame store while the input side holds ready low
module led_chase_fade_stepper_unit #(
  parameter int unsigned LED_NUM = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lcfs_in_if.sink         item_i,
  lcfs_out_if.source      result_o
);
  import lcfs_pkg::*;

  localparam int unsigned AW = $clog2(LED_NUM);
  localparam logic [AW-1:0] CUR_RESET = AW'(LED_RESET_POS % LED_NUM);
  localparam logic [AW-1:0] LAST_LED  = AW'(LED_NUM - 1);

  // stage one: accepted word plus the frame data read for it
  logic              s1_valid_q;
  op_e               s1_op_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [AW-1:0]     s1_addr_a_q;
  logic [AW-1:0]     s1_addr_b_q;
  logic              s1_fwd_a_q;
  logic              s1_fwd_b_q;
  logic [WORD_W-1:0] s1_fwd_data_q;

  logic [AW-1:0]     cur_q, cur_d;
  fade_state_t       fade_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_done_q;

  logic              clear_busy;
  logic              in_fire;
  logic              s1_adv;
  logic              s1_fire;
  logic              s1_tick;
  logic              s1_start;
  logic              s1_in_range;
  logic [WORD_W-1:0] rdata_a, rdata_b;
  logic [WORD_W-1:0] data_a, data_b;
  tick_res_t         tick_res;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;

  logic [IDX_W-1:0]  res_idx;
  logic [WORD_W-1:0] res_word;
  logic              res_done;

  assign s1_adv  = !out_valid_q || result_o.ready;
  assign s1_fire = s1_valid_q && s1_adv;
  assign item_i.ready = !clear_busy && (!s1_valid_q || s1_adv);
  assign in_fire = item_i.valid && item_i.ready;

  assign s1_tick     = (s1_op_q == OP_TICK);
  assign s1_start    = (fade_q.step == '0);
  assign s1_in_range = ({{(32 - IDX_W){1'b0}}, s1_idx_q} < 32'(LED_NUM));

  // current led as it stands once the word in stage one retires
  assign cur_d = (s1_fire && s1_tick && s1_start) ? s1_addr_b_q : cur_q;

  always_comb begin
    rd_addr_b = (cur_d == LAST_LED) ? '0 : cur_d + 1'b1;
    if (op_e'(item_i.operation) == OP_TICK) begin
      rd_addr_a = cur_d;
    end else begin
      rd_addr_a = AW'(item_i.led_index);
    end
  end

  assign mem_we    = s1_fire && (s1_tick || (s1_op_q == OP_WRITE && s1_in_range));
  assign mem_waddr = (s1_tick && s1_start) ? s1_addr_b_q : s1_addr_a_q;
  assign mem_wdata = s1_tick ? tick_res.word : s1_word_q;

  lcfs_frame_mem #(
    .DEPTH(LED_NUM)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (mem_we),
    .waddr_i     (mem_waddr),
    .wdata_i     (mem_wdata),
    .re_i        (in_fire),
    .raddr_a_i   (rd_addr_a),
    .raddr_b_i   (rd_addr_b),
    .rdata_a_o   (rdata_a),
    .rdata_b_o   (rdata_b),
    .clear_busy_o(clear_busy)
  );

  // a write retiring on the accept edge is missed by the read
  assign data_a = s1_fwd_a_q ? s1_fwd_data_q : rdata_a;
  assign data_b = s1_fwd_b_q ? s1_fwd_data_q : rdata_b;

  lcfs_tick_calc u_calc (
    .start_i(s1_start),
    .word_i (s1_start ? data_b : data_a),
    .state_i(fade_q),
    .res_o  (tick_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q       <= op_e'(item_i.operation);
      s1_idx_q      <= item_i.led_index;
      s1_word_q     <= item_i.colour_word;
      s1_addr_a_q   <= rd_addr_a;
      s1_addr_b_q   <= rd_addr_b;
      s1_fwd_a_q    <= mem_we && (mem_waddr == rd_addr_a);
      s1_fwd_b_q    <= mem_we && (mem_waddr == rd_addr_b);
      s1_fwd_data_q <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= CUR_RESET;
      fade_q <= '0;
    end else if (s1_fire && s1_tick) begin
      cur_q  <= cur_d;
      fade_q <= tick_res.state;
    end
  end

  always_comb begin
    res_idx  = s1_idx_q;
    res_word = '0;
    res_done = 1'b0;
    unique case (s1_op_q)
      OP_TICK: begin
        res_idx  = IDX_W'(s1_start ? s1_addr_b_q : s1_addr_a_q);
        res_word = tick_res.word;
        res_done = tick_res.done;
      end
      OP_WRITE: begin
        res_word = s1_in_range ? s1_word_q : '0;
      end
      OP_READ: begin
        res_word = s1_in_range ? data_a : '0;
      end
      OP_NONE: begin
        res_idx = '0;
      end
      default: begin
        res_idx = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_idx_q  <= res_idx;
      out_word_q <= res_word;
      out_done_q <= res_done;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.affected_index = out_idx_q;
  assign result_o.result_word    = out_word_q;
  assign result_o.fade_done      = out_done_q;

  a_stage_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_idx_q))
    else $error("stage one word lost under output stall");

  a_led_stays_during_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_tick && !s1_start |=> $stable(cur_q))
    else $error("current led moved while a fade was active");

  a_done_ends_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> fade_q.step == '0)
    else $error("fade done reported while a step is still active");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !in_fire && !s1_valid_q)
    else $error("word accepted during frame clearing");

endmodule

// ----- rtl/lcfs_frame_mem.sv -----
module lcfs_frame_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic [lcfs_pkg::WORD_W-1:0]         wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_b_i,
  output logic [lcfs_pkg::WORD_W-1:0]         rdata_a_o,
  output logic [lcfs_pkg::WORD_W-1:0]         rdata_b_o,
  output logic                                clear_busy_o
);
  import lcfs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_cnt_q;
  logic              clr_busy_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;

  // zero sweep after reset, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_q || we_i;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : waddr_i;
  assign mem_wdata = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o    = rdata_a_q;
  assign rdata_b_o    = rdata_b_q;
  assign clear_busy_o = clr_busy_q;

  a_no_read_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !re_i)
    else $error("frame read issued during clearing sweep");

  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !we_i)
    else $error("frame write issued during clearing sweep");

  a_sweep_ends_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> clr_cnt_q == '0 || DEPTH != (1 << AW))
    else $error("clearing sweep ended early");

endmodule

// ----- rtl/lcfs_tick_calc.sv -----
module lcfs_tick_calc (
  input  logic                              start_i,
  input  logic [lcfs_pkg::WORD_W-1:0]       word_i,
  input  lcfs_pkg::fade_state_t             state_i,
  output lcfs_pkg::tick_res_t               res_o
);
  import lcfs_pkg::*;

  logic [WORD_W-1:0]        goal;
  logic [WORD_W-1:0]        diff;
  logic [WORD_W-1:0]        biased;
  logic signed [WORD_W-1:0] new_step;
  logic signed [WORD_W-1:0] step;
  logic [WORD_W-1:0]        sum;
  logic                     clamp;

  // a new fade heads for the previous led's original word
  assign goal = start_i ? state_i.pend : state_i.goal;

  // divide by 16 truncating toward zero, then plus one
  assign diff     = goal - word_i;
  assign biased   = diff + (diff[SIGN_BIT] ? STEP_ROUND_BIAS : '0);
  assign new_step = ($signed(biased) >>> STEP_DIV_LOG2) + WORD_W'(1);
  assign step     = start_i ? new_step : state_i.step;

  assign sum = word_i + $unsigned(step);

  assign clamp = (word_i[SIGN_BIT] ^ sum[SIGN_BIT]) ||
                 (step > 0 && sum >= goal) ||
                 (step < 0 && sum <= goal);

  always_comb begin
    res_o.word       = clamp ? goal : sum;
    res_o.done       = clamp;
    res_o.state.goal = goal;
    res_o.state.pend = start_i ? word_i : state_i.pend;
    res_o.state.step = clamp ? '0 : step;
  end

endmodule
